// ----- src/toc_pkg.sv -----
`timescale 1ns / 1ps
package toc_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int ANG_W     = 8;
  localparam int MG_W      = 16;
  localparam int ORI_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_LIM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIM = 2'd3;

  localparam logic [CFG_W-1:0] BASELINE_RST = 12'd1910;
  localparam logic [CFG_W-1:0] ONE_G_RST    = 12'd365;
  localparam logic [ANG_W-1:0] UP_LIM_RST   = 8'd45;
  localparam logic [ANG_W-1:0] DOWN_LIM_RST = 8'd135;

  localparam logic [ORI_W-1:0] ORI_NONE   = 3'd0;
  localparam logic [ORI_W-1:0] ORI_X_UP   = 3'd1;
  localparam logic [ORI_W-1:0] ORI_X_DOWN = 3'd2;
  localparam logic [ORI_W-1:0] ORI_Y_UP   = 3'd3;
  localparam logic [ORI_W-1:0] ORI_Y_DOWN = 3'd4;
  localparam logic [ORI_W-1:0] ORI_Z_UP   = 3'd5;
  localparam logic [ORI_W-1:0] ORI_Z_DOWN = 3'd6;

  localparam int MAX_ANGLE   = 180;
  localparam int RIGHT_ANGLE = 90;
  localparam int MILLI       = 1000;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1073741824;

  // Cosine of k degrees with frac fraction bits, from an eleven-term Taylor series in Q30.
  // Only evaluated at elaboration to build constant tables.
  function automatic longint cos_q(input int k, input int frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned prd;
    longint unsigned term;
    longint          sum;
    longint          q;
    int              kk;
    int              n;
    kk = (k <= RIGHT_ANGLE) ? k : MAX_ANGLE - k;
    x = (longint'(kk) * PI_Q30) / 64'd180;
    x2 = (x * x) >> 30;
    term = Q30_ONE;
    sum = longint'(term);
    for (n = 1; n <= 10; n++) begin
      prd = (term * x2) >> 30;
      // Term n is divided by (2n-1)*2n.
      case (n)
        1:       term = prd / 64'd2;
        2:       term = prd / 64'd12;
        3:       term = prd / 64'd30;
        4:       term = prd / 64'd56;
        5:       term = prd / 64'd90;
        6:       term = prd / 64'd132;
        7:       term = prd / 64'd182;
        8:       term = prd / 64'd240;
        9:       term = prd / 64'd306;
        default: term = prd / 64'd380;
      endcase
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(Q30_ONE)) begin
      sum = longint'(Q30_ONE);
    end
    q = (sum + (longint'(1) << (29 - frac))) >>> (30 - frac);
    return (k <= RIGHT_ANGLE) ? q : -q;
  endfunction

endpackage

// ----- src/toc_ifs.sv -----
`timescale 1ns / 1ps
interface toc_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic [SAMPLE_BITS-1:0] z_sample;
  modport source(output valid, x_sample, y_sample, z_sample, input ready);
  modport sink(input valid, x_sample, y_sample, z_sample, output ready);
endinterface

interface toc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  x_angle;
  logic [7:0]  y_angle;
  logic [7:0]  z_angle;
  logic [15:0] milli_g;
  logic [2:0]  orientation;
  modport source(output valid, x_angle, y_angle, z_angle, milli_g, orientation, input ready);
  modport sink(input valid, x_angle, y_angle, z_angle, milli_g, orientation, output ready);
endinterface

// ----- src/tilt_orientation_classifier.sv -----
`timescale 1ns / 1ps
// A sample passes baseline removal, squaring, summing, the square root, the milli-g long
// division (the eight-step angle search runs alongside it) and the output register.
// The square root forms a D-bit root, one bit per stage, where D is one more than the
// wider of SAMPLE_BITS and 12. Throughput: one transaction per cycle unless stalled.
// Synchronous active-high reset empties the pipeline and reloads the register defaults.
module tilt_orientation_classifier import toc_pkg::*; #(
  parameter int SAMPLE_BITS   = 12,
  parameter int COS_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  toc_in_if.sink               samples,
  toc_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int D_W      = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;
  localparam int SUM_W    = 2 * D_W;
  localparam int MAG_W    = D_W;
  localparam int N_W      = MAG_W + 10;
  localparam int DV_W     = ((N_W > CFG_W + MG_W) ? N_W : CFG_W + MG_W) + 1;
  localparam int SQ_STG   = MAG_W;
  localparam int POST_STG = MG_W + 1;
  localparam int SQ0      = 3;
  localparam int PST0     = SQ0 + SQ_STG;
  localparam int NSTG     = PST0 + POST_STG + 1;

  typedef logic signed [D_W-1:0] dval_t;

  typedef struct packed {
    dval_t [2:0]      d;
    logic [SUM_W-1:0] rem;
    logic [MAG_W-1:0] root;
  } sq_t;

  typedef struct packed {
    dval_t [2:0]            d;
    logic [MAG_W-1:0]       mag;
    logic [2:0][ANG_W-1:0]  ang;
    logic                   sat;
    logic [DV_W-1:0]        rem;
    logic [MG_W-1:0]        q;
  } post_t;

  logic [CFG_W-1:0] baseline;
  logic [CFG_W-1:0] span;
  logic [ANG_W-1:0] up_lim;
  logic [ANG_W-1:0] dn_lim;
  logic [CFG_W-1:0] span_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= BASELINE_RST;
      span     <= ONE_G_RST;
      up_lim   <= UP_LIM_RST;
      dn_lim   <= DOWN_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASELINE: baseline <= cfg_wdata;
        REG_ONE_G:    span     <= cfg_wdata;
        REG_UP_LIM:   up_lim   <= cfg_wdata[ANG_W-1:0];
        REG_DOWN_LIM: dn_lim   <= cfg_wdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  assign span_eff = (span == '0) ? CFG_W'(1) : span;

  // Each stage advances when it is empty or the stage after it advances.
  logic [NSTG:0]   en;
  logic [NSTG-1:0] vld;

  assign en[NSTG] = result.ready;
  for (genvar i = 0; i < NSTG; i++) begin : g_ctl
    assign en[i] = !vld[i] || en[i+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en[i]) begin
        vld[i] <= (i == 0) ? samples.valid : vld[(i == 0) ? 0 : i - 1];
      end
    end
  end
  assign samples.ready = en[0];

  // Baseline removal.
  dval_t [2:0] d0;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0[0] <= $signed({{(D_W - SAMPLE_BITS){1'b0}}, samples.x_sample})
             - $signed({{(D_W - CFG_W){1'b0}}, baseline});
      d0[1] <= $signed({{(D_W - SAMPLE_BITS){1'b0}}, samples.y_sample})
             - $signed({{(D_W - CFG_W){1'b0}}, baseline});
      d0[2] <= $signed({{(D_W - SAMPLE_BITS){1'b0}}, samples.z_sample})
             - $signed({{(D_W - CFG_W){1'b0}}, baseline});
    end
  end

  // Squares.
  dval_t [2:0]                d1;
  logic [2:0][SUM_W-2:0]      sq1;
  logic signed [SUM_W-1:0]    prod0 [3];
  for (genvar a = 0; a < 3; a++) begin : g_sq
    assign prod0[a] = $signed(d0[a]) * $signed(d0[a]);
    always_ff @(posedge clk) begin
      if (en[1]) begin
        d1[a]  <= d0[a];
        sq1[a] <= prod0[a][SUM_W-2:0];
      end
    end
  end

  // Sum of squares.
  sq_t sq_in;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq_in.d    <= d1;
      sq_in.rem  <= SUM_W'(sq1[0]) + SUM_W'(sq1[1]) + SUM_W'(sq1[2]);
      sq_in.root <= '0;
    end
  end

  // Square root, one result bit per stage, most significant first.
  sq_t sq_q [SQ_STG];
  for (genvar s = 0; s < SQ_STG; s++) begin : g_sqrt
    localparam int B = SQ_STG - 1 - s;
    sq_t              src;
    sq_t              nxt;
    logic [SUM_W:0]   trial;
    assign src   = (s == 0) ? sq_in : sq_q[(s == 0) ? 0 : s - 1];
    assign trial = ((SUM_W + 1)'(src.root) << (B + 1)) | ((SUM_W + 1)'(1) << (2 * B));
    always_comb begin
      nxt = src;
      if ({1'b0, src.rem} >= trial) begin
        nxt.rem  = SUM_W'({1'b0, src.rem} - trial);
        nxt.root = src.root | (MAG_W'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      if (en[SQ0 + s]) begin
        sq_q[s] <= nxt;
      end
    end
  end

  // Milli-g division and angle search run side by side.
  post_t           post_q [POST_STG];
  post_t           head;
  logic [N_W-1:0]  numer;

  assign numer = N_W'(sq_q[SQ_STG-1].root) * N_W'(MILLI);
  always_comb begin
    head.d   = sq_q[SQ_STG-1].d;
    head.mag = sq_q[SQ_STG-1].root;
    head.ang = '0;
    head.sat = (DV_W'(numer) >= (DV_W'(span_eff) << MG_W));
    head.rem = DV_W'(numer);
    head.q   = '0;
  end

  for (genvar j = 0; j < POST_STG; j++) begin : g_post
    post_t src;
    post_t nxt;
    logic [2:0] ge;
    assign src = (j == 0) ? head : post_q[(j == 0) ? 0 : j - 1];

    if (j < ANG_W) begin : g_ang
      localparam int AB = ANG_W - 1 - j;
      for (genvar a = 0; a < 3; a++) begin : g_axis
        toc_cos_cmp #(
          .FRAC  (COS_FRAC_BITS),
          .D_W   (D_W),
          .MAG_W (MAG_W)
        ) u_cmp (
          .angle (src.ang[a] | (ANG_W'(1) << AB)),
          .mag   (src.mag),
          .d     (src.d[a]),
          .ge    (ge[a])
        );
      end
    end else begin : g_noang
      assign ge = '0;
    end

    always_comb begin
      nxt = src;
      for (int a = 0; a < 3; a++) begin
        if (ge[a]) begin
          nxt.ang[a] = src.ang[a] | (ANG_W'(1) << ((j < ANG_W) ? ANG_W - 1 - j : 0));
        end
      end
      if (j > 0) begin
        if (src.rem >= (DV_W'(span_eff) << ((j > 0) ? MG_W - j : 0))) begin
          nxt.rem = src.rem - (DV_W'(span_eff) << ((j > 0) ? MG_W - j : 0));
          nxt.q   = src.q | (MG_W'(1) << ((j > 0) ? MG_W - j : 0));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[PST0 + j]) begin
        post_q[j] <= nxt;
      end
    end
  end

  // Output register with orientation decode.
  post_t                 fin;
  logic [2:0][ANG_W-1:0] ang_f;
  logic [ORI_W-1:0]      ori_f;
  logic                  zero_mag;
  logic                  hit;

  assign fin      = post_q[POST_STG-1];
  assign zero_mag = (fin.mag == '0);

  always_comb begin
    ori_f = ORI_NONE;
    hit   = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ang_f[a] = zero_mag ? ANG_W'(RIGHT_ANGLE) : fin.ang[a];
    end
    if (!zero_mag) begin
      for (int a = 0; a < 3; a++) begin
        if (!hit && ang_f[a] < up_lim) begin
          ori_f = ORI_W'(2 * a + 1);
          hit   = 1'b1;
        end else if (!hit && ang_f[a] > dn_lim) begin
          ori_f = ORI_W'(2 * a + 2);
          hit   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      result.x_angle     <= ang_f[0];
      result.y_angle     <= ang_f[1];
      result.z_angle     <= ang_f[2];
      result.milli_g     <= fin.sat ? {MG_W{1'b1}} : fin.q;
      result.orientation <= ori_f;
    end
  end
  assign result.valid = vld[NSTG-1];

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid)
    else $error("result dropped while stalled");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (result.valid && !result.ready))
    else $error("input stalled while the output can drain");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.x_angle <= ANG_W'(MAX_ANGLE)) && (result.y_angle <= ANG_W'(MAX_ANGLE))
                  && (result.z_angle <= ANG_W'(MAX_ANGLE)))
    else $error("angle beyond half turn");

  a_x_up: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.orientation == ORI_X_UP) |-> (result.x_angle < up_lim))
    else $error("x up reported with angle above limit");

endmodule

// ----- src/toc_cos_cmp.sv -----
`timescale 1ns / 1ps
module toc_cos_cmp import toc_pkg::*; #(
  parameter int FRAC  = 16,
  parameter int D_W   = 13,
  parameter int MAG_W = 13
) (
  input  logic [ANG_W-1:0]        angle,
  input  logic [MAG_W-1:0]        mag,
  input  logic signed [D_W-1:0]   d,
  output logic                    ge
);

  localparam int COS_W = FRAC + 2;
  localparam int P_W   = COS_W + MAG_W + 1;

  logic signed [COS_W-1:0] cos_tab [0:MAX_ANGLE];
  logic [ANG_W-1:0]        idx;
  logic                    in_range;
  logic signed [MAG_W:0]   mag_s;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   rhs;

  for (genvar g = 0; g <= MAX_ANGLE; g++) begin : g_tab
    assign cos_tab[g] = COS_W'(cos_q(g, FRAC));
  end

  assign in_range = (angle <= ANG_W'(MAX_ANGLE));
  assign idx      = in_range ? angle : '0;
  assign mag_s    = $signed({1'b0, mag});
  assign prod     = cos_tab[idx] * mag_s;
  assign rhs      = $signed({{(P_W - D_W){d[D_W-1]}}, d}) <<< FRAC;
  assign ge       = in_range && (prod >= rhs);

endmodule
